// ===== hw/rtl/cgts_pkg.sv =====
// ----------------------------------------------------------------------------
// Class-gated task scheduler package
// Shared types, codes and constants for the scheduler core and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package cgts_pkg;

	// Default value of the fallback slice, in ns.
	localparam logic [31:0] DEFAULT_SLICE_NS = 32'd20000000;

	// Event kinds.
	localparam logic [2:0] KIND_ENQUEUE  = 3'd0;
	localparam logic [2:0] KIND_DISPATCH = 3'd1;
	localparam logic [2:0] KIND_RUNNING  = 3'd2;
	localparam logic [2:0] KIND_STOPPING = 3'd3;
	localparam logic [2:0] KIND_ENABLE   = 3'd4;

	// Queue selection codes.
	localparam logic [2:0] Q_LAT    = 3'd0;
	localparam logic [2:0] Q_BATCH  = 3'd1;
	localparam logic [2:0] Q_BG     = 3'd2;
	localparam logic [2:0] Q_SHARED = 3'd3;
	localparam logic [2:0] Q_NONE   = 3'd4;

	// Task classes.
	localparam logic [1:0] CLS_NORMAL     = 2'd0;
	localparam logic [1:0] CLS_LATENCY    = 2'd1;
	localparam logic [1:0] CLS_BATCH      = 2'd2;
	localparam logic [1:0] CLS_BACKGROUND = 2'd3;
	localparam logic [7:0] CLS_CODE_MAX   = 8'd3;

	// Gate mode in which the per-class queues are used.
	localparam logic [2:0] GATE_OPEN = 3'd2;

	// Configuration register indexes.
	localparam logic [2:0] CFG_FIFO_MODE        = 3'd0;
	localparam logic [2:0] CFG_GATE_MODE        = 3'd1;
	localparam logic [2:0] CFG_LATENCY_SLICE    = 3'd2;
	localparam logic [2:0] CFG_BATCH_SLICE      = 3'd3;
	localparam logic [2:0] CFG_BACKGROUND_SLICE = 3'd4;
	localparam logic [2:0] CFG_SHARED_SLICE     = 3'd5;
	localparam logic [2:0] CFG_STARVATION_LIMIT = 3'd6;

	// Accounting: consumed * 100 / weight.
	localparam int unsigned WEIGHT_W  = 14;
	localparam int unsigned SCALE_W   = 7;
	localparam int unsigned DIVD_W    = 32 + SCALE_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIVD_W);
	localparam logic [SCALE_W-1:0] VTIME_SCALE = SCALE_W'(100);

	typedef struct packed {
		logic [2:0]          kind;
		logic                class_found;
		logic [7:0]          class_code;
		logic [63:0]         task_vtime;
		logic [31:0]         slice_left;
		logic [WEIGHT_W-1:0] task_weight;
		logic [63:0]         now_ns;
		logic [3:0]          queues_nonempty;
	} cgts_in_t;

	typedef struct packed {
		logic [2:0]  queue_sel;
		logic        vtime_ordered;
		logic [31:0] slice_out;
		logic [63:0] vtime_out;
		logic        starvation_taken;
		logic [1:0]  effective_class;
		logic [31:0] consumed_out;
	} cgts_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} cgts_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/class_gated_task_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// Class-gated task scheduler core
// Maps scheduler events to queue choices, slices and virtual time updates,
// using one shared 64-bit adder and a bit-serial divider under a sequencer.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+------------------------------
//  in       | into core | in_valid/in_ready  | in_data (cgts_in_t)
//  out      | from core | out_valid/out_ready| out_data (cgts_out_t)
//  cfg      | into core | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Every transaction other than a stopping one outside fifo mode goes from
// acceptance to a loaded result through capture, a prepare cycle and a
// finish cycle. The shared adder works in the prepare cycle for enqueue and
// dispatch, and in the finish cycle for enqueue, running and stopping.
// A stopping transaction outside fifo mode adds the multiply state and then
// the divide state, which yields one quotient bit a cycle.
// Reset clears the sequencer, the configuration registers to their defaults
// and both time registers. The core takes no new input while a transaction is
// in flight; a finished result waits in the output register while the next
// input is accepted, and a stalled output holds the finish cycle.
// The configuration channel is always ready.

`default_nettype none

module class_gated_task_scheduler_core
	import cgts_pkg::*;
#(
	parameter logic [31:0] DEFAULT_SLICE = DEFAULT_SLICE_NS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire cgts_in_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output cgts_out_t        out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	// Configuration registers.
	logic        fifo_mode_q;
	logic [2:0]  gate_mode_q;
	logic [31:0] latency_slice_q;
	logic [31:0] batch_slice_q;
	logic [31:0] background_slice_q;
	logic [31:0] shared_slice_q;
	logic [31:0] starvation_limit_q;

	// Scheduler state.
	logic [63:0] global_vtime_q;
	logic [63:0] last_bg_time_q;

	// Sequencer and per-transaction working registers.
	cgts_state_t          state_q, state_d;
	cgts_in_t             in_q;
	logic [1:0]           cls_q;
	logic [31:0]          slice_q;
	logic [2:0]           queue_q;
	logic [31:0]          used_q;
	logic [63:0]          acc_q;
	logic [WEIGHT_W-1:0]  divisor_q;
	logic [DIVD_W-1:0]    quot_q;
	logic [WEIGHT_W-1:0]  rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	// Output register.
	logic      out_valid_q;
	cgts_out_t out_q;

	// Control decoded from the sequencer state.
	logic accept;
	logic load_out;

	// -------------------------------------------------------------------
	// Class, slice and queue lookup from the captured event.
	// -------------------------------------------------------------------
	logic        gate_act;
	logic [1:0]  cls;
	logic [31:0] slice_raw;
	logic [31:0] slice;
	logic [2:0]  queue;
	logic [31:0] used;

	always_comb begin
		gate_act = (gate_mode_q == GATE_OPEN);
		cls = (in_q.class_found && in_q.class_code <= CLS_CODE_MAX) ?
			in_q.class_code[1:0] : CLS_NORMAL;
		slice_raw = shared_slice_q;
		queue = Q_SHARED;
		if (gate_act) begin
			case (cls)
				CLS_LATENCY: begin
					slice_raw = latency_slice_q;
					queue = Q_LAT;
				end
				CLS_BATCH: begin
					slice_raw = batch_slice_q;
					queue = Q_BATCH;
				end
				CLS_BACKGROUND: begin
					slice_raw = background_slice_q;
					queue = Q_BG;
				end
				default: begin
					slice_raw = shared_slice_q;
					queue = Q_SHARED;
				end
			endcase
		end
		slice = (slice_raw != 32'd0) ? slice_raw : DEFAULT_SLICE;
		if (fifo_mode_q || slice <= in_q.slice_left) begin
			used = 32'd0;
		end else begin
			used = slice - in_q.slice_left;
		end
	end

	// -------------------------------------------------------------------
	// Shared 64-bit adder. In the prepare cycle it forms global vtime less
	// the slice, or the time since the last background dispatch; in the
	// finish cycle it does the wrap-aware compare or the vtime charge.
	// -------------------------------------------------------------------
	logic [63:0] add_a;
	logic [63:0] add_b;
	logic        add_sub;
	logic [63:0] add_sum;

	always_comb begin
		add_a = 64'd0;
		add_b = 64'd0;
		add_sub = 1'b0;
		if (state_q == ST_PREP) begin
			case (in_q.kind)
				KIND_ENQUEUE: begin
					add_a = global_vtime_q;
					add_b = {32'd0, slice};
					add_sub = 1'b1;
				end
				KIND_DISPATCH: begin
					add_a = in_q.now_ns;
					add_b = last_bg_time_q;
					add_sub = 1'b1;
				end
				default: begin
					add_a = 64'd0;
				end
			endcase
		end else if (state_q == ST_FIN) begin
			case (in_q.kind)
				KIND_ENQUEUE: begin
					add_a = in_q.task_vtime;
					add_b = acc_q;
					add_sub = 1'b1;
				end
				KIND_RUNNING: begin
					add_a = global_vtime_q;
					add_b = in_q.task_vtime;
					add_sub = 1'b1;
				end
				KIND_STOPPING: begin
					add_a = in_q.task_vtime;
					add_b = {{(64 - DIVD_W){1'b0}}, quot_q};
				end
				default: begin
					add_a = 64'd0;
				end
			endcase
		end
		add_sum = add_a + (add_sub ? ~add_b : add_b) + {63'd0, add_sub};
	end

	// -------------------------------------------------------------------
	// Divider step: restoring division, one quotient bit a cycle. The
	// dividend is shifted out of the top of quot_q as quotient bits enter.
	// -------------------------------------------------------------------
	logic [WEIGHT_W:0]   rem_shift;
	logic                rem_ge;
	logic [WEIGHT_W:0]   rem_diff;

	always_comb begin
		rem_shift = {rem_q, quot_q[DIVD_W-1]};
		rem_ge = (rem_shift >= {1'b0, divisor_q});
		rem_diff = rem_shift - {1'b0, divisor_q};
	end

	// -------------------------------------------------------------------
	// Result of the finish cycle.
	// -------------------------------------------------------------------
	logic      starved;
	logic      ordered;
	cgts_out_t res;
	logic      bg_taken;
	logic      gv_raise;

	always_comb begin
		starved = (last_bg_time_q == 64'd0) || (acc_q[63:32] != 32'd0) ||
			(acc_q[31:0] >= starvation_limit_q);
		ordered = !fifo_mode_q && (queue_q == Q_SHARED);
		bg_taken = 1'b0;
		gv_raise = 1'b0;
		res = '0;
		res.queue_sel = Q_NONE;
		case (in_q.kind)
			KIND_ENQUEUE: begin
				res.queue_sel = queue_q;
				res.vtime_ordered = ordered;
				res.slice_out = slice_q;
				res.vtime_out = (ordered && add_sum[63]) ? acc_q : in_q.task_vtime;
				res.effective_class = cls_q;
			end
			KIND_DISPATCH: begin
				if (in_q.queues_nonempty[0]) begin
					res.queue_sel = Q_LAT;
				end else if (starved && in_q.queues_nonempty[2]) begin
					res.queue_sel = Q_BG;
					res.starvation_taken = 1'b1;
					bg_taken = 1'b1;
				end else if (in_q.queues_nonempty[1]) begin
					res.queue_sel = Q_BATCH;
				end else if (in_q.queues_nonempty[2]) begin
					res.queue_sel = Q_BG;
					bg_taken = 1'b1;
				end else if (in_q.queues_nonempty[3]) begin
					res.queue_sel = Q_SHARED;
				end
			end
			KIND_RUNNING: begin
				gv_raise = !fifo_mode_q && add_sum[63];
				res.vtime_out = in_q.task_vtime;
				res.effective_class = cls_q;
			end
			KIND_STOPPING: begin
				res.slice_out = slice_q;
				res.vtime_out = fifo_mode_q ? in_q.task_vtime : add_sum;
				res.effective_class = cls_q;
				res.consumed_out = used_q;
			end
			KIND_ENABLE: begin
				res.vtime_out = global_vtime_q;
			end
			default: begin
				res.queue_sel = Q_NONE;
			end
		endcase
	end

	// -------------------------------------------------------------------
	// Sequencer: next state.
	// -------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				if (in_q.kind == KIND_STOPPING && !fifo_mode_q) begin
					state_d = ST_MUL;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_MUL: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// -------------------------------------------------------------------
	// Sequencer: control outputs.
	// -------------------------------------------------------------------
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		accept = in_valid && in_ready;
		load_out = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// -------------------------------------------------------------------
	// Control registers.
	// -------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			global_vtime_q <= 64'd0;
			last_bg_time_q <= 64'd0;
			fifo_mode_q <= 1'b0;
			gate_mode_q <= 3'd0;
			latency_slice_q <= 32'd1000000;
			batch_slice_q <= 32'd6000000;
			background_slice_q <= 32'd2000000;
			shared_slice_q <= 32'd0;
			starvation_limit_q <= 32'd20000000;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
				if (gv_raise) begin
					global_vtime_q <= in_q.task_vtime;
				end
				if (bg_taken) begin
					last_bg_time_q <= in_q.now_ns;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_FIFO_MODE:        fifo_mode_q <= cfg_data[0];
					CFG_GATE_MODE:        gate_mode_q <= cfg_data[2:0];
					CFG_LATENCY_SLICE:    latency_slice_q <= cfg_data;
					CFG_BATCH_SLICE:      batch_slice_q <= cfg_data;
					CFG_BACKGROUND_SLICE: background_slice_q <= cfg_data;
					CFG_SHARED_SLICE:     shared_slice_q <= cfg_data;
					CFG_STARVATION_LIMIT: starvation_limit_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	// -------------------------------------------------------------------
	// Payload and datapath registers.
	// -------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= in_data;
		end
		if (state_q == ST_PREP) begin
			cls_q <= cls;
			slice_q <= slice;
			queue_q <= queue;
			used_q <= used;
			acc_q <= add_sum;
			divisor_q <= (in_q.task_weight == '0) ? WEIGHT_W'(1) : in_q.task_weight;
		end
		if (state_q == ST_MUL) begin
			quot_q <= DIVD_W'(used_q) * DIVD_W'(VTIME_SCALE);
			rem_q <= '0;
			cnt_q <= DIV_CNT_W'(DIVD_W - 1);
		end
		if (state_q == ST_DIV) begin
			quot_q <= {quot_q[DIVD_W-2:0], rem_ge};
			rem_q <= rem_ge ? rem_diff[WEIGHT_W-1:0] : rem_shift[WEIGHT_W-1:0];
			cnt_q <= cnt_q - DIV_CNT_W'(1);
		end
		if (load_out) begin
			out_q <= res;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cgts_checker.sv =====
// ----------------------------------------------------------------------------
// Class-gated task scheduler checker
// Port-level assertions on the scheduler core, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module cgts_checker
	import cgts_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire cgts_out_t out_data,
	input wire logic      cfg_ready
);

	// One transaction is in flight at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted again while a transaction is in flight");

	// A result needs at least a prepare and a finish cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared in the cycle after acceptance");

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	// Queue selection is always a defined code.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.queue_sel <= Q_NONE))
		else $error("queue selection out of range");

	// Configuration is never back-pressured.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration channel not ready");

endmodule

bind class_gated_task_scheduler_core cgts_checker u_cgts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_ready (cfg_ready)
);

`default_nettype wire
